/* rtl/smp_pkg.sv */
// ---------------------------------------------------------------------------
// smp_pkg: shared types and constants for the skinning matrix palette
// Command and status structures between controller and datapath, operand
// codes for the shared multiplier and the saturation helper.
// ---------------------------------------------------------------------------
package smp_pkg;

	localparam int VAL_W         = 32;
	localparam int JNT_W         = 6;
	localparam int ROW_W         = 2;
	localparam int CNT_W         = 7;
	localparam int ACC_W         = 66;
	localparam int IDX_W         = 4;
	localparam int ENTRIES       = 12;
	localparam int DEF_MAX_JOINTS = 64;
	localparam int DEF_FRAC_BITS  = 16;

	localparam logic OPC_BIND = 1'b0;
	localparam logic OPC_POSE = 1'b1;

	// operand codes for the multiplier inputs
	typedef enum logic [3:0] {
		OP_S, OP_W, OP_X, OP_Y, OP_Z, OP_PM, OP_WLD, OP_LOC, OP_BM, OP_ONE
	} opnd_t;

	// destination of a finished sum of products
	typedef enum logic [1:0] {
		K_ROT, K_LOC, K_WLD, K_SKN
	} kind_t;

	typedef struct packed {
		logic             issue;
		logic             first;
		logic             last;
		opnd_t            a_sel;
		logic [IDX_W-1:0] a_idx;
		opnd_t            b_sel;
		logic [IDX_W-1:0] b_idx;
		logic             neg;
		kind_t            kind;
		logic             diag;
		logic [IDX_W-1:0] dest;
	} mac_cmd_t;

	typedef struct packed {
		mac_cmd_t         mac;
		logic             bind_we;
		logic             cap;
		logic             rd_en;
		logic [ROW_W-1:0] rd_row;
		logic             rd_par;
		logic             ld_en;
		logic [ROW_W-1:0] ld_row;
		logic             copy;
		logic             wwr;
		logic [ROW_W-1:0] wwr_row;
		logic             out_ld;
		logic [ROW_W-1:0] out_row;
		logic             err;
	} dp_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_sts_t;

	// clamp a wide signed sum to 32 bits
	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		if (&v[ACC_W-1:VAL_W-1] || ~|v[ACC_W-1:VAL_W-1])
			return v[VAL_W-1:0];
		else if (v[ACC_W-1])
			return {1'b1, {(VAL_W-1){1'b0}}};
		else
			return {1'b0, {(VAL_W-1){1'b1}}};
	endfunction

endpackage

/* rtl/smp_ctrl.sv */
// ---------------------------------------------------------------------------
// smp_ctrl: sequencer of the skinning matrix palette
// Accepts words, keeps the joint count and steps the datapath through
// matrix reads, rotation build, local scaling, world and skin products.
// ---------------------------------------------------------------------------
module smp_ctrl #(
	parameter int MAX_JOINTS = smp_pkg::DEF_MAX_JOINTS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [smp_pkg::JNT_W-1:0]  joint_number,
	input  logic [smp_pkg::JNT_W-1:0]  parent_number,
	input  logic [smp_pkg::ROW_W-1:0]  row_number,
	input  logic                       cfg_write,
	input  logic [smp_pkg::CNT_W-1:0]  cfg_data,
	input  logic                       out_stall,
	input  smp_pkg::dp_sts_t           sts,
	output smp_pkg::dp_cmd_t           cmd
);
	import smp_pkg::*;

	localparam logic [1:0] ROW_LAST = 2'd2;
	localparam logic [1:0] COL_LAST = 2'd3;
	localparam logic [1:0] PRD_LAST = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_ROT, S_LOC, S_WLD, S_COPY, S_WWR, S_SKN, S_DRAIN, S_OUT
	} state_t;

	typedef struct packed {
		opnd_t a;
		opnd_t b;
		logic  neg;
	} rot_term_t;

	state_t           state_q, nxt_q;
	logic [1:0]       i_q, j_q, t_q;
	logic             err_q, usep_q;
	logic [CNT_W-1:0] jc_q;

	logic             accept, pose_ok, bind_ok, par_err, mac_last;
	logic [8:0]       j9;
	rot_term_t        rt;

	// pair products of the quaternion rotation entries
	function automatic rot_term_t rot_term(input logic [1:0] i, input logic [1:0] j,
		input logic t);
		rot_term_t r;
		r = '{a: OP_X, b: OP_X, neg: 1'b0};
		unique case ({i, j, t})
			5'b00_00_0: r = '{a: OP_Y, b: OP_Y, neg: 1'b0};
			5'b00_00_1: r = '{a: OP_Z, b: OP_Z, neg: 1'b0};
			5'b00_01_0: r = '{a: OP_X, b: OP_Y, neg: 1'b0};
			5'b00_01_1: r = '{a: OP_W, b: OP_Z, neg: 1'b1};
			5'b00_10_0: r = '{a: OP_X, b: OP_Z, neg: 1'b0};
			5'b00_10_1: r = '{a: OP_W, b: OP_Y, neg: 1'b0};
			5'b01_00_0: r = '{a: OP_X, b: OP_Y, neg: 1'b0};
			5'b01_00_1: r = '{a: OP_W, b: OP_Z, neg: 1'b0};
			5'b01_01_0: r = '{a: OP_X, b: OP_X, neg: 1'b0};
			5'b01_01_1: r = '{a: OP_Z, b: OP_Z, neg: 1'b0};
			5'b01_10_0: r = '{a: OP_Y, b: OP_Z, neg: 1'b0};
			5'b01_10_1: r = '{a: OP_W, b: OP_X, neg: 1'b1};
			5'b10_00_0: r = '{a: OP_X, b: OP_Z, neg: 1'b0};
			5'b10_00_1: r = '{a: OP_W, b: OP_Y, neg: 1'b1};
			5'b10_01_0: r = '{a: OP_Y, b: OP_Z, neg: 1'b0};
			5'b10_01_1: r = '{a: OP_W, b: OP_X, neg: 1'b0};
			5'b10_10_0: r = '{a: OP_X, b: OP_X, neg: 1'b0};
			5'b10_10_1: r = '{a: OP_Y, b: OP_Y, neg: 1'b0};
			default:    r = '{a: OP_X, b: OP_X, neg: 1'b0};
		endcase
		return r;
	endfunction

	// decode the offered word
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign j9       = 9'(joint_number);
	assign pose_ok  = (j9 < 9'(jc_q)) && (j9 < 9'(MAX_JOINTS));
	assign bind_ok  = (row_number <= ROW_LAST) && (j9 < 9'(MAX_JOINTS));
	assign par_err  = (joint_number != '0) && (parent_number >= joint_number);
	assign mac_last = (j_q == COL_LAST) ? (t_q == COL_LAST) : (t_q == PRD_LAST);
	assign rt       = rot_term(i_q, j_q, t_q[0]);

	// sequence state, counters and joint count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nxt_q   <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			t_q     <= '0;
			err_q   <= 1'b0;
			usep_q  <= 1'b0;
			jc_q    <= CNT_W'(1);
		end else begin
			if (cfg_write) begin
				jc_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == OPC_POSE && pose_ok) begin
						err_q   <= par_err;
						usep_q  <= (joint_number != '0) && !par_err;
						i_q     <= '0;
						j_q     <= '0;
						t_q     <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (t_q == 2'd3) begin
						t_q     <= '0;
						state_q <= S_ROT;
					end else begin
						t_q <= t_q + 2'd1;
					end
				end
				S_ROT: begin
					if (t_q[0]) begin
						t_q <= '0;
						if (j_q == ROW_LAST) begin
							j_q <= '0;
							if (i_q == ROW_LAST) begin
								i_q     <= '0;
								nxt_q   <= S_LOC;
								state_q <= S_DRAIN;
							end else begin
								i_q <= i_q + 2'd1;
							end
						end else begin
							j_q <= j_q + 2'd1;
						end
					end else begin
						t_q <= 2'd1;
					end
				end
				S_LOC: begin
					if (j_q == ROW_LAST) begin
						j_q <= '0;
						if (i_q == ROW_LAST) begin
							i_q     <= '0;
							nxt_q   <= usep_q ? S_WLD : S_COPY;
							state_q <= S_DRAIN;
						end else begin
							i_q <= i_q + 2'd1;
						end
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				S_WLD, S_SKN: begin
					if (mac_last) begin
						t_q <= '0;
						if (j_q == COL_LAST) begin
							j_q <= '0;
							if (i_q == ROW_LAST) begin
								i_q     <= '0;
								nxt_q   <= (state_q == S_WLD) ? S_WWR : S_OUT;
								state_q <= S_DRAIN;
							end else begin
								i_q <= i_q + 2'd1;
							end
						end else begin
							j_q <= j_q + 2'd1;
						end
					end else begin
						t_q <= t_q + 2'd1;
					end
				end
				S_COPY: begin
					state_q <= S_WWR;
				end
				S_WWR: begin
					if (i_q == ROW_LAST) begin
						i_q     <= '0;
						state_q <= S_SKN;
					end else begin
						i_q <= i_q + 2'd1;
					end
				end
				S_DRAIN: begin
					if (t_q[0]) begin
						t_q     <= '0;
						state_q <= nxt_q;
					end else begin
						t_q <= 2'd1;
					end
				end
				S_OUT: begin
					if (!sts.out_full || !out_stall) begin
						if (i_q == ROW_LAST) begin
							i_q     <= '0;
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// drive datapath commands from the current step
	always_comb begin
		cmd         = '0;
		cmd.bind_we = accept && opcode == OPC_BIND && bind_ok;
		cmd.cap     = accept && opcode == OPC_POSE && pose_ok;
		cmd.rd_par  = usep_q;
		cmd.err     = err_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.rd_en  = (t_q != 2'd3);
				cmd.rd_row = t_q;
				cmd.ld_en  = (t_q != 2'd0);
				cmd.ld_row = t_q - 2'd1;
			end
			S_ROT: begin
				cmd.mac.issue = 1'b1;
				cmd.mac.first = !t_q[0];
				cmd.mac.last  = t_q[0];
				cmd.mac.a_sel = rt.a;
				cmd.mac.b_sel = rt.b;
				cmd.mac.neg   = rt.neg;
				cmd.mac.kind  = K_ROT;
				cmd.mac.diag  = (i_q == j_q);
				cmd.mac.dest  = {i_q, j_q};
			end
			S_LOC: begin
				cmd.mac.issue = 1'b1;
				cmd.mac.first = 1'b1;
				cmd.mac.last  = 1'b1;
				cmd.mac.a_sel = OP_S;
				cmd.mac.b_sel = OP_LOC;
				cmd.mac.b_idx = {i_q, j_q};
				cmd.mac.kind  = K_LOC;
				cmd.mac.dest  = {i_q, j_q};
			end
			S_WLD, S_SKN: begin
				cmd.mac.issue = 1'b1;
				cmd.mac.first = (t_q == 2'd0);
				cmd.mac.last  = mac_last;
				cmd.mac.a_sel = (state_q == S_WLD) ? OP_PM : OP_WLD;
				cmd.mac.a_idx = {i_q, t_q};
				cmd.mac.b_sel = (t_q == COL_LAST) ? OP_ONE :
					((state_q == S_WLD) ? OP_LOC : OP_BM);
				cmd.mac.b_idx = {t_q, j_q};
				cmd.mac.kind  = (state_q == S_WLD) ? K_WLD : K_SKN;
				cmd.mac.dest  = {i_q, j_q};
			end
			S_COPY: cmd.copy = 1'b1;
			S_WWR: begin
				cmd.wwr     = 1'b1;
				cmd.wwr_row = i_q;
			end
			S_OUT: begin
				cmd.out_ld  = !sts.out_full || !out_stall;
				cmd.out_row = i_q;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_last_row_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld && cmd.out_row == ROW_LAST |=> !in_stall)
		else $error("controller did not return to idle after the last row");
	a_entry_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac.issue && cmd.mac.last |=> !cmd.mac.issue || cmd.mac.first)
		else $error("sum of products continued past its last term");
	a_bind_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bind_we |-> !cmd.mac.issue && !cmd.wwr)
		else $error("bind row write during pose work");
`endif

endmodule

/* rtl/smp_dpath.sv */
// ---------------------------------------------------------------------------
// smp_dpath: datapath of the skinning matrix palette
// Row-wide bind and world stores, working matrices, one shared 32x32
// multiplier with accumulator and rounding, and the output word register.
// ---------------------------------------------------------------------------
module smp_dpath #(
	parameter int MAX_JOINTS = smp_pkg::DEF_MAX_JOINTS,
	parameter int FRAC_BITS  = smp_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smp_pkg::dp_cmd_t                  cmd,
	output smp_pkg::dp_sts_t                  sts,
	input  logic [smp_pkg::JNT_W-1:0]         joint_number,
	input  logic [smp_pkg::JNT_W-1:0]         parent_number,
	input  logic [smp_pkg::ROW_W-1:0]         row_number,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_0,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_1,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_2,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_3,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_4,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_5,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_6,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_7,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [smp_pkg::JNT_W-1:0]         out_joint,
	output logic [smp_pkg::ROW_W-1:0]         out_row,
	output logic signed [smp_pkg::VAL_W-1:0]  entry_0,
	output logic signed [smp_pkg::VAL_W-1:0]  entry_1,
	output logic signed [smp_pkg::VAL_W-1:0]  entry_2,
	output logic signed [smp_pkg::VAL_W-1:0]  entry_3,
	output logic                              last_row,
	output logic                              parent_error
);
	import smp_pkg::*;

	localparam int DEPTH = MAX_JOINTS * 3;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (AW > 8) ? AW : 8;
	localparam int ROW_BITS = 4 * VAL_W;
	localparam logic signed [VAL_W-1:0] ONE   = VAL_W'(1) <<< FRAC_BITS;
	localparam logic signed [ACC_W-1:0] ONE_A = ACC_W'(1) <<< FRAC_BITS;
	localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = 2'd2;

	logic [ROW_BITS-1:0] bind_mem  [DEPTH];
	logic [ROW_BITS-1:0] world_mem [DEPTH];
	logic [ROW_BITS-1:0] bind_rd_q, world_rd_q;

	logic signed [VAL_W-1:0] vq  [5];
	logic signed [VAL_W-1:0] loc [ENTRIES];
	logic signed [VAL_W-1:0] wld [ENTRIES];
	logic signed [VAL_W-1:0] pm  [ENTRIES];
	logic signed [VAL_W-1:0] bm  [ENTRIES];
	logic [JNT_W-1:0]        joint_q, parent_q;

	logic signed [VAL_W-1:0] a_val, b_val, rnd, rot;
	logic signed [63:0]      prod, p_s1;
	logic signed [ACC_W-1:0] acc_q, term, shifted, dbl, rot_w;
	mac_cmd_t                mac_s1, mac_s2, mac_nx;
	logic                    out_valid_q;

	function automatic logic [AW-1:0] row_addr(input logic [JNT_W-1:0] j,
		input logic [ROW_W-1:0] r);
		logic [CW-1:0] a;
		a = (CW'(j) << 1) + CW'(j) + CW'(r);
		return a[AW-1:0];
	endfunction

	// bind store: written on load words, read a row at a time
	always_ff @(posedge clk) begin
		if (cmd.bind_we)
			bind_mem[row_addr(joint_number, row_number)] <= {value_3, value_2, value_1, value_0};
		if (cmd.rd_en)
			bind_rd_q <= bind_mem[row_addr(joint_q, cmd.rd_row)];
	end

	// world store: parent rows out, finished world rows in
	always_ff @(posedge clk) begin
		if (cmd.wwr)
			world_mem[row_addr(joint_q, cmd.wwr_row)] <=
				{wld[{cmd.wwr_row, 2'd3}], wld[{cmd.wwr_row, 2'd2}],
				 wld[{cmd.wwr_row, 2'd1}], wld[{cmd.wwr_row, 2'd0}]};
		if (cmd.rd_en)
			world_rd_q <= world_mem[row_addr(cmd.rd_par ? parent_q : joint_q, cmd.rd_row)];
	end

	// multiplier operand selection
	always_comb begin
		unique case (cmd.mac.a_sel)
			OP_S:    a_val = vq[0];
			OP_W:    a_val = vq[1];
			OP_X:    a_val = vq[2];
			OP_Y:    a_val = vq[3];
			OP_Z:    a_val = vq[4];
			OP_PM:   a_val = pm[cmd.mac.a_idx];
			OP_WLD:  a_val = wld[cmd.mac.a_idx];
			default: a_val = '0;
		endcase
		unique case (cmd.mac.b_sel)
			OP_W:    b_val = vq[1];
			OP_X:    b_val = vq[2];
			OP_Y:    b_val = vq[3];
			OP_Z:    b_val = vq[4];
			OP_LOC:  b_val = loc[cmd.mac.b_idx];
			OP_BM:   b_val = bm[cmd.mac.b_idx];
			OP_ONE:  b_val = ONE;
			default: b_val = '0;
		endcase
	end

	assign prod = 64'(a_val) * 64'(b_val);
	assign term = mac_s1.neg ? -ACC_W'(p_s1) : ACC_W'(p_s1);

	// round half up, saturate; rotation entries are doubled, diagonal ones taken from one
	assign shifted = (acc_q + HALF) >>> FRAC_BITS;
	assign rnd     = sat32(shifted);
	assign dbl     = ACC_W'(rnd) <<< 1;
	assign rot_w   = mac_s2.diag ? (ONE_A - dbl) : dbl;
	assign rot     = sat32(rot_w);

	// product and accumulator stages
	always_ff @(posedge clk) begin
		p_s1 <= prod;
		if (mac_s1.issue)
			acc_q <= (mac_s1.first ? '0 : acc_q) + term;
	end

	// keep only the closing term of a sum as a write request
	always_comb begin
		mac_nx       = mac_s1;
		mac_nx.issue = mac_s1.issue && mac_s1.last;
	end

	// carry the command along the multiply and accumulate stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= '0;
			mac_s2 <= '0;
		end else begin
			mac_s1 <= cmd.mac;
			mac_s2 <= mac_nx;
		end
	end

	// working matrices
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			vq[0] <= value_0;
			vq[1] <= value_1;
			vq[2] <= value_2;
			vq[3] <= value_3;
			vq[4] <= value_4;
			joint_q  <= joint_number;
			parent_q <= parent_number;
			loc[3]   <= value_5;
			loc[7]   <= value_6;
			loc[11]  <= value_7;
		end
		if (cmd.ld_en) begin
			for (int c = 0; c < 4; c++) begin
				pm[{cmd.ld_row, 2'(c)}] <= world_rd_q[c*VAL_W +: VAL_W];
				bm[{cmd.ld_row, 2'(c)}] <= bind_rd_q[c*VAL_W +: VAL_W];
			end
		end
		if (cmd.copy) begin
			for (int e = 0; e < ENTRIES; e++)
				wld[e] <= loc[e];
		end
		if (mac_s2.issue) begin
			unique case (mac_s2.kind)
				K_ROT: loc[mac_s2.dest] <= rot;
				K_LOC: loc[mac_s2.dest] <= rnd;
				K_WLD: wld[mac_s2.dest] <= rnd;
				K_SKN: pm[mac_s2.dest]  <= rnd;
				default: ;
			endcase
		end
	end

	// output word: hold while stalled, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_joint    <= joint_q;
			out_row      <= cmd.out_row;
			entry_0      <= pm[{cmd.out_row, 2'd0}];
			entry_1      <= pm[{cmd.out_row, 2'd1}];
			entry_2      <= pm[{cmd.out_row, 2'd2}];
			entry_3      <= pm[{cmd.out_row, 2'd3}];
			last_row     <= (cmd.out_row == ROW_LAST);
			parent_error <= cmd.err;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_full = out_valid_q;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !out_valid_q || !out_stall)
		else $error("output word overwritten while stalled");
	a_cap_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |-> !mac_s1.issue && !mac_s2.issue)
		else $error("new pose captured with products in flight");
	a_wwr_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wwr |-> !mac_s1.issue && !mac_s2.issue)
		else $error("world row stored before the world matrix settled");
`endif

endmodule

/* rtl/skinning_matrix_palette.sv */
// Pose flow: a pose word is accepted only in idle; no further word, bind or pose, is
// accepted until its three skin rows are loaded into the output word. With a valid parent the
// single shared multiplier does 18 rotation, 9 scale, 39 world and 39 skin products; for the
// root or a bad parent the world products are skipped and the local matrix is copied instead.
// Reset: control and the joint count (back to 1) clear at once; stores are not cleared.
// ---------------------------------------------------------------------------
// skinning_matrix_palette: forward-kinematics skinning matrix engine
// Stores inverse bind rows, builds local and world matrices per posed joint
// and emits the three rows of world times inverse bind.
// ---------------------------------------------------------------------------
module skinning_matrix_palette #(
	parameter int MAX_JOINTS = smp_pkg::DEF_MAX_JOINTS,
	parameter int FRAC_BITS  = smp_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [smp_pkg::CNT_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic [smp_pkg::JNT_W-1:0]         joint_number,
	input  logic [smp_pkg::JNT_W-1:0]         parent_number,
	input  logic [smp_pkg::ROW_W-1:0]         row_number,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_0,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_1,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_2,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_3,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_4,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_5,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_6,
	input  logic signed [smp_pkg::VAL_W-1:0]  value_7,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [smp_pkg::JNT_W-1:0]         out_joint,
	output logic [smp_pkg::ROW_W-1:0]         out_row,
	output logic signed [smp_pkg::VAL_W-1:0]  entry_0,
	output logic signed [smp_pkg::VAL_W-1:0]  entry_1,
	output logic signed [smp_pkg::VAL_W-1:0]  entry_2,
	output logic signed [smp_pkg::VAL_W-1:0]  entry_3,
	output logic                              last_row,
	output logic                              parent_error
);
	import smp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer
	smp_ctrl #(
		.MAX_JOINTS(MAX_JOINTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.joint_number  (joint_number),
		.parent_number (parent_number),
		.row_number    (row_number),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.out_stall     (out_stall),
		.sts           (sts),
		.cmd           (cmd)
	);

	// stores, multiplier and output word
	smp_dpath #(
		.MAX_JOINTS(MAX_JOINTS),
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.joint_number  (joint_number),
		.parent_number (parent_number),
		.row_number    (row_number),
		.value_0       (value_0),
		.value_1       (value_1),
		.value_2       (value_2),
		.value_3       (value_3),
		.value_4       (value_4),
		.value_5       (value_5),
		.value_6       (value_6),
		.value_7       (value_7),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.out_joint     (out_joint),
		.out_row       (out_row),
		.entry_0       (entry_0),
		.entry_1       (entry_1),
		.entry_2       (entry_2),
		.entry_3       (entry_3),
		.last_row      (last_row),
		.parent_error  (parent_error)
	);

endmodule
